// File: sv/allgather_schedule_generator_assert.svh
// Assertion macros used by the top level of the allgather schedule generator RTL.
`ifndef ALLGATHER_SCHEDULE_GENERATOR_ASSERT_SVH
`define ALLGATHER_SCHEDULE_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define AGS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define AGS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AGS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define AGS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// File: sv/ags_pkg.sv
// Types, widths and helper functions of the allgather schedule generator.
`timescale 1ns / 1ps
package ags_pkg;

    localparam int unsigned FIELD_W = 10;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned IDX_W   = 11;
    localparam int unsigned BH_W    = 12;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned CNT_MAX = 2047;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 3;

    localparam logic REG_MY_RANK    = 1'b0;
    localparam logic REG_PROC_COUNT = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] my_rank;
        logic [CNT_W-1:0]   proc_count;
    } cfg_regs_t;

    typedef struct packed {
        logic              active;
        logic [STEP_W-1:0] step_count;
        logic [STEP_W-1:0] step_total;
        logic [IDX_W-1:0]  inner_index;
        logic [IDX_W-1:0]  distance;
        logic [BH_W-1:0]   blocks_held;
        logic [CNT_W-1:0]  skip_mask;
        logic [IDX_W-1:0]  next_send_block;
        logic [IDX_W-1:0]  next_recv_block;
        logic [IDX_W-1:0]  rank;
        logic [CNT_W-1:0]  count;
    } sched_state_t;

    function automatic logic [IDX_W-1:0] sub_mod(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b,
                                                 input logic [CNT_W-1:0] p);
        logic [IDX_W:0] r;
        begin
            if (a >= b) begin
                r = {1'b0, a} - {1'b0, b};
            end else begin
                r = {1'b0, a} + {1'b0, p} - {1'b0, b};
            end
            return r[IDX_W-1:0];
        end
    endfunction

endpackage

// File: sv/ags_cfg.sv
// APB-style configuration registers holding rank and process count.
`timescale 1ns / 1ps
module ags_cfg import ags_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_regs_t         cfg
);

    logic [FIELD_W-1:0] rank_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg  <= '0;
            count_reg <= CNT_W'(1);
        end else if (wr_en) begin
            case (paddr[2])
                REG_MY_RANK: begin
                    rank_reg <= pwdata[FIELD_W-1:0];
                end
                REG_PROC_COUNT: begin
                    count_reg <= pwdata[CNT_W-1:0];
                end
                default: begin
                    rank_reg <= rank_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MY_RANK:    prdata = {{(DATA_W-FIELD_W){1'b0}}, rank_reg};
            REG_PROC_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, count_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.my_rank    = rank_reg;
    assign cfg.proc_count = count_reg;

endmodule

// File: sv/ags_init.sv
// Start-of-schedule state derived from the configuration registers.
`timescale 1ns / 1ps
module ags_init import ags_pkg::*; #(
    parameter int unsigned MAX_PROCS     = 1024,
    parameter int unsigned LOG_MAX_PROCS = 10
) (
    input  cfg_regs_t    cfg,
    output sched_state_t init_state
);

    localparam int unsigned CLAMP   = (MAX_PROCS > CNT_MAX) ? CNT_MAX : MAX_PROCS;
    localparam int unsigned LOG_LIM = (LOG_MAX_PROCS > CNT_W) ? CNT_W : LOG_MAX_PROCS;
    localparam logic [CNT_W-1:0]  CLAMP_V = CNT_W'(CLAMP);
    localparam logic [STEP_W-1:0] LOG_V   = STEP_W'(LOG_LIM);

    logic [CNT_W-1:0]  p;
    logic [CNT_W-1:0]  p_m1;
    logic [IDX_W-1:0]  rank;
    logic [STEP_W-1:0] bit_len;
    logic [STEP_W-1:0] steps;
    logic [CNT_W-1:0]  low_bit;
    logic [CNT_W-1:0]  mask;
    logic [IDX_W-1:0]  start_dist;
    logic              act;

    always_comb begin
        if (cfg.proc_count == '0) begin
            p = CNT_W'(1);
        end else if (cfg.proc_count > CLAMP_V) begin
            p = CLAMP_V;
        end else begin
            p = cfg.proc_count;
        end
        p_m1 = p - CNT_W'(1);

        if ({1'b0, cfg.my_rank} < p) begin
            rank = {1'b0, cfg.my_rank};
        end else begin
            rank = p_m1;
        end

        bit_len = '0;
        for (int k = 0; k < CNT_W; k++) begin
            if (p_m1[k]) begin
                bit_len = STEP_W'(k + 1);
            end
        end
        steps = (bit_len > LOG_V) ? LOG_V : bit_len;

        // Odd part of the count, inverted, with bit zero forced, shifted back up.
        low_bit = p & (~p + CNT_W'(1));
        mask    = (~p & ~(low_bit - CNT_W'(1))) | low_bit;

        act        = (steps != '0);
        start_dist = act ? (IDX_W'(1) << (steps - STEP_W'(1))) : '0;
    end

    always_comb begin
        init_state.active          = act;
        init_state.step_count      = '0;
        init_state.step_total      = steps;
        init_state.inner_index     = '0;
        init_state.distance        = start_dist;
        init_state.blocks_held     = BH_W'(1);
        init_state.skip_mask       = mask;
        init_state.next_send_block = act ? rank : '0;
        init_state.next_recv_block = act ? sub_mod(rank, start_dist, p) : '0;
        init_state.rank            = rank;
        init_state.count           = p;
    end

endmodule

// File: sv/allgather_schedule_generator.sv
// Top level of the allgather schedule generator: schedule state, step logic, result register.
`timescale 1ns / 1ps
`include "allgather_schedule_generator_assert.svh"
// Each accepted request yields one transfer descriptor of the logarithmic allgather schedule
// for the rank and process count latched at the last restart. A request is taken every cycle
// and its descriptor appears in the result register on the next cycle; the input side keeps
// accepting while a finished descriptor waits, as long as the result register is emptied. The
// one exception is a step that exchanges no blocks: each such step passes through the skip
// state of the step logic, during which no request is taken. With the default parameters no
// schedule contains such a step. A request after the schedule has ended returns a
// descriptor with valid_res low and all other fields zero.
module allgather_schedule_generator import ags_pkg::*; #(
    parameter int unsigned MAX_PROCS     = 1024,
    parameter int unsigned LOG_MAX_PROCS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_valid_res,
    output logic [STEP_W-1:0]  m_step_index,
    output logic [FIELD_W-1:0] m_send_peer,
    output logic [FIELD_W-1:0] m_recv_peer,
    output logic [FIELD_W-1:0] m_send_block,
    output logic [FIELD_W-1:0] m_recv_block,
    output logic               m_last_in_step,
    output logic               m_last_overall
);

    cfg_regs_t    cfg;
    sched_state_t init_state;
    sched_state_t state_reg, state_next;
    sched_state_t cur;
    logic         skip_reg, skip_next;
    logic         out_free, s_fire, go, emit;
    logic         ig, empty, lis, lov;
    logic [BH_W-1:0]    len;
    logic [IDX_W:0]     peer_sum;
    logic [IDX_W-1:0]   peer_up, peer_dn;
    logic [IDX_W:0]     d2_raw;
    logic [IDX_W-1:0]   d2;

    logic               m_valid_reg, m_valid_next;
    logic               m_valid_res_reg;
    logic [STEP_W-1:0]  m_step_index_reg;
    logic [FIELD_W-1:0] m_send_peer_reg, m_recv_peer_reg;
    logic [FIELD_W-1:0] m_send_block_reg, m_recv_block_reg;
    logic               m_last_in_step_reg, m_last_overall_reg;

    logic               step_in_range, res_none, res_fields_zero, res_last, res_last_ok;

    ags_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ags_init #(
        .MAX_PROCS     (MAX_PROCS),
        .LOG_MAX_PROCS (LOG_MAX_PROCS)
    ) u_init (
        .cfg        (cfg),
        .init_state (init_state)
    );

    function automatic sched_state_t reset_state();
        sched_state_t r;
        begin
            r             = '0;
            r.blocks_held = BH_W'(1);
            r.count       = CNT_W'(1);
            return r;
        end
    endfunction

    function automatic sched_state_t finish_step(input sched_state_t s, input logic ign);
        sched_state_t      r;
        logic [STEP_W-1:0] sc;
        begin
            r             = s;
            r.blocks_held = (s.blocks_held << 1) - BH_W'(ign);
            r.distance    = s.distance >> 1;
            sc            = s.step_count + STEP_W'(1);
            r.step_count  = sc;
            if (sc >= s.step_total) begin
                r.active = 1'b0;
            end else begin
                r.inner_index     = '0;
                r.next_send_block = s.rank;
                r.next_recv_block = sub_mod(s.rank, r.distance, s.count);
            end
            return r;
        end
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !skip_reg && out_free;
    assign s_fire   = s_valid && s_ready;
    assign go       = s_fire || (skip_reg && out_free);

    always_comb begin
        cur   = (s_fire && s_restart) ? init_state : state_reg;
        ig    = |(cur.distance & cur.skip_mask);
        len   = (cur.blocks_held > BH_W'(ig)) ? (cur.blocks_held - BH_W'(ig)) : '0;
        empty = cur.active && (len == '0);
        lis   = (({1'b0, cur.inner_index} + BH_W'(1)) >= len);
        lov   = lis && (({1'b0, cur.step_count} + (STEP_W+1)'(1)) >= {1'b0, cur.step_total});

        peer_sum = {1'b0, cur.rank} + {1'b0, cur.distance};
        if (peer_sum >= {1'b0, cur.count}) begin
            peer_sum = peer_sum - {1'b0, cur.count};
        end
        peer_up = peer_sum[IDX_W-1:0];
        peer_dn = sub_mod(cur.rank, cur.distance, cur.count);

        d2_raw = {cur.distance, 1'b0};
        if (d2_raw >= {1'b0, cur.count}) begin
            d2_raw = d2_raw - {1'b0, cur.count};
        end
        d2 = d2_raw[IDX_W-1:0];

        state_next = state_reg;
        skip_next  = skip_reg;
        emit       = 1'b0;
        if (go) begin
            if (empty) begin
                state_next = finish_step(cur, ig);
                skip_next  = 1'b1;
            end else begin
                skip_next = 1'b0;
                emit      = 1'b1;
                if (!cur.active) begin
                    state_next = cur;
                end else if (lis) begin
                    state_next = finish_step(cur, ig);
                end else begin
                    state_next                 = cur;
                    state_next.inner_index     = cur.inner_index + IDX_W'(1);
                    state_next.next_send_block = sub_mod(cur.next_send_block, d2, cur.count);
                    state_next.next_recv_block = sub_mod(cur.next_recv_block, d2, cur.count);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= reset_state();
            skip_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            skip_reg  <= skip_next;
        end
    end

    assign m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_valid_res_reg    <= cur.active;
            m_step_index_reg   <= cur.active ? cur.step_count : '0;
            m_send_peer_reg    <= cur.active ? peer_up[FIELD_W-1:0] : '0;
            m_recv_peer_reg    <= cur.active ? peer_dn[FIELD_W-1:0] : '0;
            m_send_block_reg   <= cur.active ? cur.next_send_block[FIELD_W-1:0] : '0;
            m_recv_block_reg   <= cur.active ? cur.next_recv_block[FIELD_W-1:0] : '0;
            m_last_in_step_reg <= cur.active && lis;
            m_last_overall_reg <= cur.active && lov;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_valid_res    = m_valid_res_reg;
    assign m_step_index   = m_step_index_reg;
    assign m_send_peer    = m_send_peer_reg;
    assign m_recv_peer    = m_recv_peer_reg;
    assign m_send_block   = m_send_block_reg;
    assign m_recv_block   = m_recv_block_reg;
    assign m_last_in_step = m_last_in_step_reg;
    assign m_last_overall = m_last_overall_reg;

    assign step_in_range   = state_reg.step_count < state_reg.step_total;
    assign res_none        = m_valid_reg && !m_valid_res_reg;
    assign res_fields_zero = (m_step_index_reg == '0) && (m_send_peer_reg == '0)
                             && (m_recv_peer_reg == '0) && (m_send_block_reg == '0)
                             && (m_recv_block_reg == '0) && !m_last_in_step_reg
                             && !m_last_overall_reg;
    assign res_last        = m_valid_reg && m_last_overall_reg;
    assign res_last_ok     = m_last_in_step_reg && m_valid_res_reg;

    `AGS_ASSERT_IMPLY(a_active_in_range, aclk, aresetn, state_reg.active, step_in_range, "step overrun")
    `AGS_ASSERT_IMPLY(a_empty_result_zero, aclk, aresetn, res_none, res_fields_zero, "fields not zero")
    `AGS_ASSERT_IMPLY(a_last_overall_ends_step, aclk, aresetn, res_last, res_last_ok, "bad last flag")
    `AGS_ASSERT_NEXT(a_emit_loads_result, aclk, aresetn, emit, m_valid_reg, "result not loaded")

endmodule
